// ----- rtl/rkrm_pkg.sv -----
`default_nettype none
package rkrm_pkg;

  // largest interval that can still be rare, plus one
  localparam int MAX_RARE    = 32;
  // stored members of one open interval
  localparam int STORE_DEPTH = MAX_RARE - 1;
  // interval size counter, holds 0 .. MAX_RARE
  localparam int SIZE_W      = $clog2(MAX_RARE + 1);

  localparam int READ_W  = 32;
  localparam int TOTAL_W = 40;
  localparam int LEN_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RARE_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SEQUENCES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIRRORED      = 3'd3;

  // one stored interval member
  typedef struct packed {
    logic [READ_W-1:0] read;
    logic              elig;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/rare_kmer_read_marker_top.sv -----
`default_nettype none
// Each item passes the steps accept, append and finish; the stored members of every rare
// interval it closes are drained from the cell chain, which sets how soon it is done.
// A result stalled at the output holds the drain only when another result is due.
// A result waits in the hold stage until the next eligible member or the finish step
// moves it to the output register. Synchronous reset clears state,
// total and output; registers go to k=32, limit=8, 0 sequences, not mirrored.
module rare_kmer_read_marker_top (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rkrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rkrm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // suffix input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rkrm_pkg::LEN_W-1:0]        lcp_to_previous,
  input  logic [rkrm_pkg::READ_W-1:0]       seq_number,
  input  logic [rkrm_pkg::LEN_W-1:0]        rel_position,
  input  logic [rkrm_pkg::LEN_W-1:0]        seq_length,
  input  logic                              last_of_bucket,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rkrm_pkg::READ_W-1:0]       read_index,
  output logic [rkrm_pkg::TOTAL_W-1:0]      rare_total,
  output logic                              last_of_run
);
  import rkrm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DRAIN1 = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_DRAIN2 = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam int CMP_W = SIZE_W + 1;

  logic [2:0] state;

  // configuration registers
  logic [LEN_W-1:0]  kmer_length;
  logic [5:0]        rare_limit;
  logic [READ_W-1:0] num_sequences;
  logic              mirrored;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length   <= LEN_W'(32);
      rare_limit    <= 6'd8;
      num_sequences <= '0;
      mirrored      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KMER_LENGTH:   kmer_length   <= cfg_data[LEN_W-1:0];
        REG_RARE_LIMIT:    rare_limit    <= cfg_data[5:0];
        REG_NUM_SEQUENCES: num_sequences <= cfg_data;
        REG_MIRRORED:      mirrored      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [READ_W-1:0] item_seq;
  logic [LEN_W-1:0]  item_pos;
  logic [LEN_W-1:0]  item_len;
  logic              item_last;

  logic [SIZE_W-1:0]  size;
  logic [SIZE_W-1:0]  remaining;
  logic [TOTAL_W-1:0] rare_count;
  logic               hold_valid;
  logic [READ_W-1:0]  hold_read;
  logic [TOTAL_W-1:0] hold_total;

  assign in_ready = (state == S_IDLE);
  wire accept = in_valid && in_ready;

  // rare test against the current limit, capped by MAX_RARE
  function automatic logic is_rare(input logic [SIZE_W-1:0] sz, input logic [5:0] lim);
    is_rare = (CMP_W'(sz) < CMP_W'(lim)) && (CMP_W'(sz) < CMP_W'(MAX_RARE));
  endfunction

  function automatic logic [SIZE_W-1:0] drain_len(input logic [SIZE_W-1:0] sz);
    drain_len = (sz < SIZE_W'(STORE_DEPTH)) ? sz : SIZE_W'(STORE_DEPTH);
  endfunction

  // mirroring and eligibility for the append step
  logic [READ_W-1:0] nreads;
  logic [READ_W-1:0] mapped_seq;
  logic              item_elig;
  logic [LEN_W-1:0]  remain_len;
  logic [SIZE_W-1:0] size_inc;

  always_comb begin
    nreads     = mirrored ? (num_sequences >> 1) : num_sequences;
    mapped_seq = (item_seq >= nreads) ? (num_sequences - item_seq - READ_W'(1)) : item_seq;
    remain_len = item_len - item_pos;
    item_elig  = (item_pos <= item_len) && (remain_len >= kmer_length);
    size_inc   = (size < SIZE_W'(MAX_RARE)) ? size + SIZE_W'(1) : size;
  end

  // cell chain
  entry_t     cell_data [STORE_DEPTH];
  cell_ctrl_t cell_ctrl [STORE_DEPTH];
  entry_t     new_entry;
  entry_t     head;

  logic draining;
  logic out_free;
  logic advance;
  logic [TOTAL_W-1:0] count_inc;

  assign new_entry = '{read: mapped_seq, elig: item_elig};
  assign head      = cell_data[0];
  assign draining  = (state == S_DRAIN1) || (state == S_DRAIN2);
  assign out_free  = !out_valid || out_ready;
  assign advance   = draining && (!head.elig || !hold_valid || out_free);
  assign count_inc = (rare_count == TOTAL_MAX) ? rare_count : rare_count + TOTAL_W'(1);

  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
    entry_t nb;
    if (g == STORE_DEPTH - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_data[g+1];
    end
    assign cell_ctrl[g].shift = advance;
    assign cell_ctrl[g].load  = (state == S_APPEND) && (size == SIZE_W'(g));
    rkrm_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .load_data (new_entry),
      .neighbor  (nb),
      .data      (cell_data[g])
    );
  end

  // sequencer, hold stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      size       <= '0;
      remaining  <= '0;
      rare_count <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_seq  <= seq_number;
            item_pos  <= rel_position;
            item_len  <= seq_length;
            item_last <= last_of_bucket;
            state     <= S_APPEND;
            if (size != '0 && lcp_to_previous < kmer_length) begin
              if (is_rare(size, rare_limit)) begin
                remaining <= drain_len(size);
                state     <= S_DRAIN1;
              end else begin
                size <= '0;
              end
            end
          end
        end
        S_DRAIN1, S_DRAIN2: begin
          if (advance) begin
            remaining <= remaining - SIZE_W'(1);
            if (head.elig) begin
              if (hold_valid) begin
                out_valid   <= 1'b1;
                read_index  <= hold_read;
                rare_total  <= hold_total;
                last_of_run <= 1'b0;
              end
              hold_valid <= 1'b1;
              hold_read  <= head.read;
              hold_total <= count_inc;
              rare_count <= count_inc;
            end
            if (remaining == SIZE_W'(1)) begin
              size  <= '0;
              state <= (state == S_DRAIN1) ? S_APPEND : S_FINISH;
            end
          end
        end
        S_APPEND: begin
          size  <= size_inc;
          state <= S_FINISH;
          if (item_last) begin
            if (is_rare(size_inc, rare_limit)) begin
              remaining <= drain_len(size_inc);
              state     <= S_DRAIN2;
            end else begin
              size <= '0;
            end
          end
        end
        S_FINISH: begin
          // the held result is the last of this run
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            read_index  <= hold_read;
            rare_total  <= hold_total;
            last_of_run <= 1'b1;
            hold_valid  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rkrm_cell.sv -----
`default_nettype none
module rkrm_cell (
  input  logic                clk,
  input  rkrm_pkg::cell_ctrl_t ctrl,
  input  rkrm_pkg::entry_t    load_data,
  input  rkrm_pkg::entry_t    neighbor,
  output rkrm_pkg::entry_t    data
);
  import rkrm_pkg::*;

  // shift toward the head during a drain, otherwise capture a new member
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= neighbor;
    end else if (ctrl.load) begin
      data <= load_data;
    end
  end

endmodule
`default_nettype wire
